### sv/ltpm_pkg.sv
// Package for the LUT truth-table merge block: shared constants, item types,
// sequencer states and the internal table command.
// No dependencies.
package ltpm_pkg;

  localparam int ELEMENT_WIDTH_DEF = 64;
  localparam int MAX_PINS_DEF      = 6;
  localparam int MAP_PINS          = 6;
  localparam int MAP_W             = 4;
  localparam int MAP_MAX           = 5;
  localparam int MAP_IDX_W         = 3;
  localparam int CELL_ADDR_W       = 6;
  localparam int CELL_W            = 64;
  localparam int PIN_CNT_W         = 3;
  localparam int OFFSET_W          = 6;
  localparam int POS_W             = 7;
  localparam int MASK_W            = 64;

  localparam logic MODE_CLEAR = 1'b0;
  localparam logic MODE_MERGE = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [CELL_W-1:0]       cell_table;
    logic [PIN_CNT_W-1:0]    pin_count;
    logic [OFFSET_W-1:0]     low_offset;
    logic [MAP_PINS-1:0]     used_pin_mask;
    logic signed [MAP_W-1:0] pin_map_0;
    logic signed [MAP_W-1:0] pin_map_1;
    logic signed [MAP_W-1:0] pin_map_2;
    logic signed [MAP_W-1:0] pin_map_3;
    logic signed [MAP_W-1:0] pin_map_4;
    logic signed [MAP_W-1:0] pin_map_5;
  } in_item_t;

  typedef struct packed {
    logic              merge_ok;
    logic [MASK_W-1:0] known_mask;
    logic [MASK_W-1:0] ones_mask;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // result of mapping one LUT address
  typedef struct packed {
    logic             reach;
    logic             cell_bit;
    logic [POS_W-1:0] pos;
  } map_res_t;

  // command to the entry table
  typedef struct packed {
    logic             wr;
    logic             clr;
    logic [POS_W-1:0] pos;
    logic             val;
  } tbl_cmd_t;

endpackage

### sv/ltpm_addr_unit.sv
// Address mapping unit: turns one LUT address into a reachability flag, the
// cell output bit and the table position. Depends on ltpm_pkg.
module ltpm_addr_unit #(
  parameter int MAX_PINS = ltpm_pkg::MAX_PINS_DEF
) (
  input  logic [MAX_PINS-1:0]                        addr,
  input  logic [ltpm_pkg::PIN_CNT_W-1:0]             np,
  input  logic [MAX_PINS-1:0]                        used,
  input  logic [MAX_PINS-1:0]                        map_en,
  input  logic [MAX_PINS-1:0][ltpm_pkg::MAP_IDX_W-1:0] map_idx,
  input  logic [ltpm_pkg::OFFSET_W-1:0]              offset,
  input  logic [ltpm_pkg::CELL_W-1:0]                cell_table,
  output ltpm_pkg::map_res_t                         res
);
  import ltpm_pkg::*;

  logic                   reach;
  logic [CELL_ADDR_W-1:0] cell_addr;

  always_comb begin
    reach     = 1'b1;
    cell_addr = '0;
    for (int p = 0; p < MAX_PINS; p++) begin
      if (PIN_CNT_W'(p) < np) begin
        if (!addr[p]) begin
          if (!used[p]) begin
            reach = 1'b0;
          end
        end else if (map_en[p]) begin
          cell_addr[map_idx[p]] = 1'b1;
        end
      end
    end
  end

  assign res.reach    = reach;
  assign res.cell_bit = cell_table[cell_addr];
  assign res.pos      = POS_W'(offset) + POS_W'(addr);

endmodule

### sv/ltpm_table.sv
// Entry table: known and ones bit per entry, one entry written per cycle,
// with conflict check against the opposite known value. Depends on ltpm_pkg.
module ltpm_table #(
  parameter int ELEMENT_WIDTH = ltpm_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ltpm_pkg::tbl_cmd_t       cmd,
  output logic                     conflict,
  output logic [ELEMENT_WIDTH-1:0] known,
  output logic [ELEMENT_WIDTH-1:0] ones
);
  import ltpm_pkg::*;

  localparam int IDX_W = $clog2(ELEMENT_WIDTH);

  logic             in_range;
  logic [IDX_W-1:0] idx;

  assign in_range = cmd.pos < POS_W'(ELEMENT_WIDTH);
  assign idx      = cmd.pos[IDX_W-1:0];
  assign conflict = cmd.wr && in_range && known[idx] && (ones[idx] != cmd.val);

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      known <= '0;
      ones  <= '0;
    end else if (cmd.wr && in_range && !conflict) begin
      known[idx] <= 1'b1;
      ones[idx]  <= cmd.val;
    end
  end

endmodule

### sv/ltpm_ctrl.sv
// Sequencer: takes an item, steps the LUT address one per cycle through the
// mapping unit, drives table writes and the result strobe. Depends on ltpm_pkg.
module ltpm_ctrl #(
  parameter int MAX_PINS = ltpm_pkg::MAX_PINS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  input  ltpm_pkg::in_item_t                           cmd,
  output logic                                         busy,
  output logic                                         done,
  output logic                                         ok,
  output logic [MAX_PINS-1:0]                          addr,
  output logic [ltpm_pkg::PIN_CNT_W-1:0]               np,
  output logic [MAX_PINS-1:0]                          used,
  output logic [MAX_PINS-1:0]                          map_en,
  output logic [MAX_PINS-1:0][ltpm_pkg::MAP_IDX_W-1:0] map_idx,
  output logic [ltpm_pkg::OFFSET_W-1:0]                offset,
  output logic [ltpm_pkg::CELL_W-1:0]                  cell_table,
  input  ltpm_pkg::map_res_t                           res,
  input  logic                                         conflict,
  output ltpm_pkg::tbl_cmd_t                           tcmd
);
  import ltpm_pkg::*;

  state_t                              state;
  state_t                              state_next;
  logic                                accept;
  logic [MAX_PINS-1:0]                 last;
  logic [MAX_PINS-1:0]                 last_next;
  logic [PIN_CNT_W-1:0]                np_sat;
  logic [MAP_PINS-1:0][MAP_W-1:0]      pm;

  assign accept = start && !busy;
  assign np_sat = (cmd.pin_count > PIN_CNT_W'(MAX_PINS)) ? PIN_CNT_W'(MAX_PINS)
                                                         : cmd.pin_count;
  assign pm = {cmd.pin_map_5, cmd.pin_map_4, cmd.pin_map_3,
               cmd.pin_map_2, cmd.pin_map_1, cmd.pin_map_0};

  always_comb begin
    for (int p = 0; p < MAX_PINS; p++) begin
      last_next[p] = PIN_CNT_W'(p) < np_sat;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          state_next = (cmd.mode == MODE_MERGE) ? ST_RUN : ST_DONE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (conflict || addr == last) begin
          state_next = ST_DONE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    done     = 1'b0;
    tcmd.wr  = 1'b0;
    tcmd.clr = accept && (cmd.mode == MODE_CLEAR);
    tcmd.pos = res.pos;
    tcmd.val = res.cell_bit;
    case (state)
      ST_RUN: begin
        busy    = 1'b1;
        tcmd.wr = res.reach;
      end
      ST_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok         <= 1'b1;
      addr       <= '0;
      last       <= last_next;
      np         <= np_sat;
      used       <= cmd.used_pin_mask[MAX_PINS-1:0];
      offset     <= cmd.low_offset;
      cell_table <= cmd.cell_table;
      for (int p = 0; p < MAX_PINS; p++) begin
        map_en[p]  <= $unsigned(pm[p]) <= MAP_W'(MAP_MAX);
        map_idx[p] <= pm[p][MAP_IDX_W-1:0];
      end
    end else if (state == ST_RUN) begin
      addr <= addr + 1'b1;
      if (conflict) begin
        ok <= 1'b0;
      end
    end
  end

endmodule

### sv/lut_truth_table_permute_merge.sv
// Top level of the LUT truth-table merge block: sequencer, address mapping
// unit and entry table. Depends on ltpm_pkg, ltpm_ctrl, ltpm_addr_unit, ltpm_table.
//
// An item is taken when start is high and busy is low. A clear item shows its
// result in the cycle after it is taken. A merge item visits one LUT address per
// cycle through the single mapping unit, so it visits 2^pin_count addresses, with
// pin_count capped at MAX_PINS (fewer when a conflict stops it), and its result
// comes in the cycle after the last address it visits. The result is on the result
// port for exactly one cycle, marked by done; the receiver cannot stall it. A new
// item may be taken in the same cycle that done is high.
module lut_truth_table_permute_merge #(
  parameter int ELEMENT_WIDTH = ltpm_pkg::ELEMENT_WIDTH_DEF,
  parameter int MAX_PINS      = ltpm_pkg::MAX_PINS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ltpm_pkg::in_item_t  cmd,
  output logic                busy,
  output logic                done,
  output ltpm_pkg::out_item_t result
);
  import ltpm_pkg::*;

  logic                               ok;
  logic [MAX_PINS-1:0]                addr;
  logic [PIN_CNT_W-1:0]               np;
  logic [MAX_PINS-1:0]                used;
  logic [MAX_PINS-1:0]                map_en;
  logic [MAX_PINS-1:0][MAP_IDX_W-1:0] map_idx;
  logic [OFFSET_W-1:0]                offset;
  logic [CELL_W-1:0]                  cell_table;
  map_res_t                           res;
  logic                               conflict;
  tbl_cmd_t                           tcmd;
  logic [ELEMENT_WIDTH-1:0]           known;
  logic [ELEMENT_WIDTH-1:0]           ones;

  ltpm_ctrl #(.MAX_PINS(MAX_PINS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done),
    .ok         (ok),
    .addr       (addr),
    .np         (np),
    .used       (used),
    .map_en     (map_en),
    .map_idx    (map_idx),
    .offset     (offset),
    .cell_table (cell_table),
    .res        (res),
    .conflict   (conflict),
    .tcmd       (tcmd)
  );

  ltpm_addr_unit #(.MAX_PINS(MAX_PINS)) u_addr (
    .addr       (addr),
    .np         (np),
    .used       (used),
    .map_en     (map_en),
    .map_idx    (map_idx),
    .offset     (offset),
    .cell_table (cell_table),
    .res        (res)
  );

  ltpm_table #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_table (
    .clk      (clk),
    .rst      (rst),
    .cmd      (tcmd),
    .conflict (conflict),
    .known    (known),
    .ones     (ones)
  );

  assign result.merge_ok   = ok;
  assign result.known_mask = MASK_W'(known);
  assign result.ones_mask  = MASK_W'(ones);

endmodule

### bench/lut_truth_table_permute_merge_tb.sv
// Testbench for lut_truth_table_permute_merge: directed and random clear/merge
// items checked against an in-bench prediction of the three-valued table.
// Depends on ltpm_pkg and the block's RTL.
`timescale 1ns / 100ps

module lut_truth_table_permute_merge_tb;
  import ltpm_pkg::*;

  localparam int N_ITEMS    = 1000;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL       = 80;

  typedef struct packed {
    logic       drain;
    logic [7:0] gap;
    in_item_t   item;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  cmd = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  stim_t     stim_q[$];
  out_item_t expected_q[$];
  out_item_t want;

  logic [MASK_W-1:0] entry_known = '0;
  logic [MASK_W-1:0] entry_one = '0;

  int wait_cycles = 0;
  int n_sent = 0;
  int n_rcvd = 0;
  int idle_cnt = 0;
  int errors = 0;
  int n_items = 0;
  int n_clears = 0;
  int n_merges = 0;
  int n_conflicts = 0;

  // fold one item into the predicted table and return the result it gives
  function automatic out_item_t merge_into_table(in_item_t it);
    out_item_t r;
    logic signed [MAP_W-1:0] raw [MAP_PINS];
    int lut_map [MAP_PINS];
    int npins, span, pos, cell_addr;
    bit reach, stop, want_one;
    r.merge_ok = 1'b1;
    raw[0] = it.pin_map_0;
    raw[1] = it.pin_map_1;
    raw[2] = it.pin_map_2;
    raw[3] = it.pin_map_3;
    raw[4] = it.pin_map_4;
    raw[5] = it.pin_map_5;
    if (it.mode == MODE_CLEAR) begin
      entry_known = '0;
      entry_one = '0;
    end else begin
      for (int p = 0; p < MAP_PINS; p++)
        lut_map[p] = (raw[p] < 0 || raw[p] > MAP_MAX) ? -1 : int'(raw[p]);
      npins = (it.pin_count > MAX_PINS_DEF) ? MAX_PINS_DEF : int'(it.pin_count);
      span = 1 << npins;
      stop = 1'b0;
      for (int a = 0; a < span && !stop; a++) begin
        reach = 1'b1;
        cell_addr = 0;
        for (int p = 0; p < npins; p++) begin
          if (!a[p]) begin
            if (!it.used_pin_mask[p]) reach = 1'b0;
          end else if (lut_map[p] >= 0) begin
            cell_addr |= 1 << lut_map[p];
          end
        end
        pos = int'(it.low_offset) + a;
        if (reach && pos < ELEMENT_WIDTH_DEF) begin
          want_one = it.cell_table[cell_addr];
          if (entry_known[pos] && entry_one[pos] != want_one) begin
            r.merge_ok = 1'b0;
            stop = 1'b1;
          end else begin
            entry_known[pos] = 1'b1;
            entry_one[pos] = want_one;
          end
        end
      end
    end
    r.known_mask = entry_known;
    r.ones_mask = entry_one;
    return r;
  endfunction

  function automatic logic signed [MAP_W-1:0] rand_map();
    if ($urandom_range(0, 4) != 0) return MAP_W'($urandom_range(0, 6) - 1);
    return MAP_W'($urandom_range(0, 15));
  endfunction

  function automatic in_item_t rand_merge();
    in_item_t it;
    int sel;
    sel = $urandom_range(0, 9);
    it.mode = MODE_MERGE;
    it.cell_table = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
    if ($urandom_range(0, 19) == 0)
      it.pin_count = $urandom_range(0, 1) ? 3'd7 : 3'd0;
    else
      it.pin_count = PIN_CNT_W'($urandom_range(1, 6));
    it.low_offset = OFFSET_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 63));
    it.used_pin_mask = ($urandom_range(0, 2) == 0) ? 6'h3f
                                                   : MAP_PINS'($urandom_range(0, 63));
    it.pin_map_0 = rand_map();
    it.pin_map_1 = rand_map();
    it.pin_map_2 = rand_map();
    it.pin_map_3 = rand_map();
    it.pin_map_4 = rand_map();
    it.pin_map_5 = rand_map();
    return it;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic push_item(in_item_t it, int gap);
    stim_t s;
    s.drain = 1'b0;
    s.gap = 8'(gap);
    s.item = it;
    stim_q = {stim_q, s};
    n_items++;
    if (it.mode == MODE_CLEAR) n_clears++;
    else n_merges++;
  endtask

  task automatic push_drain();
    stim_t s;
    s = '0;
    s.drain = 1'b1;
    stim_q = {stim_q, s};
  endtask

  lut_truth_table_permute_merge u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #6 clk = ~clk;

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      wait_cycles <= 0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_q = {expected_q, merge_into_table(cmd)};
        n_sent <= n_sent + 1;
      end
      if (wait_cycles != 0) begin
        wait_cycles <= wait_cycles - 1;
        start <= 1'b0;
      end else if (stim_q.size() != 0 && stim_q[0].drain) begin
        start <= 1'b0;
        if (!start && !busy && n_sent == n_rcvd) void'(stim_q.pop_front());
      end else if (stim_q.size() != 0) begin
        cmd <= stim_q[0].item;
        wait_cycles <= int'(stim_q[0].gap);
        start <= 1'b1;
        void'(stim_q.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (!want.merge_ok) n_conflicts++;
        if (result.merge_ok !== want.merge_ok) begin
          $error("merge_ok expected %0b got %0b", want.merge_ok, result.merge_ok);
          errors++;
        end
        if (result.known_mask !== want.known_mask) begin
          $error("known_mask expected %h got %h", want.known_mask, result.known_mask);
          errors++;
        end
        if (result.ones_mask !== want.ones_mask) begin
          $error("ones_mask expected %h got %h", want.ones_mask, result.ones_mask);
          errors++;
        end
      end
      n_rcvd <= n_rcvd + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    in_item_t it;
    in_item_t base;
    int r;

    // directed
    push_item('{MODE_CLEAR, 64'h0, 3'd0, 6'd0, 6'h00, 0, 0, 0, 0, 0, 0}, 0);
    // pin count zero: single address mapping to cell bit 0
    push_item('{MODE_MERGE, 64'h1, 3'd0, 6'd0, 6'h00, 0, 1, 2, 3, 4, 5}, 0);
    push_item('{MODE_MERGE, 64'hdead_beef_0123_4567, 3'd6, 6'd0, 6'h3f, 0, 1, 2, 3, 4, 5}, 0);
    push_item('{MODE_MERGE, 64'hdead_beef_0123_4567, 3'd6, 6'd0, 6'h3f, 0, 1, 2, 3, 4, 5}, 1);
    // inverted table clashes on the first address
    push_item('{MODE_MERGE, ~64'hdead_beef_0123_4567, 3'd6, 6'd0, 6'h3f, 0, 1, 2, 3, 4, 5}, 0);
    push_item('{MODE_CLEAR, 64'hffff_ffff_ffff_ffff, 3'd7, 6'd63, 6'h3f, -1, -1, -1, -1, -1, -1}, 0);
    // pin count above six saturates; only address zero fits at offset 63
    push_item('{MODE_MERGE, 64'hffff_ffff_ffff_ffff, 3'd7, 6'd63, 6'h3f, 5, 4, 3, 2, 1, 0}, 0);
    // no used pins: only the all-ones address is reachable
    push_item('{MODE_MERGE, 64'h8000_0000_0000_0080, 3'd3, 6'd0, 6'h00, 0, 1, 7, 3, 4, 5}, 2);
    // map values above five and negative ones add no bit to the cell address
    push_item('{MODE_MERGE, 64'h5a5a_a5a5_0ff0_f00f, 3'd6, 6'd10, 6'h2a, 6, 7, -8, -1, 5, 0}, 0);
    push_item('{MODE_MERGE, 64'hffff_ffff_ffff_ffff, 3'd5, 6'd32, 6'h1f, 0, 1, 2, 3, 4, 5}, 0);
    push_item('{MODE_MERGE, 64'h0, 3'd6, 6'd0, 6'h3f, 0, 1, 2, 3, 4, 5}, 0);
    push_item('{MODE_CLEAR, 64'h0, 3'd0, 6'd0, 6'h00, 0, 0, 0, 0, 0, 0}, 0);
    push_item('{MODE_MERGE, 64'h2, 3'd1, 6'd62, 6'h01, 0, 0, 0, 0, 0, 0}, 0);
    push_item('{MODE_MERGE, 64'h1, 3'd1, 6'd63, 6'h01, 1, 0, 0, 0, 0, 0}, 0);
    push_item('{MODE_MERGE, 64'h0, 3'd2, 6'd20, 6'h02, 1, 0, -1, -1, -1, -1}, 3);
    push_item('{MODE_MERGE, 64'hffff_0000_ffff_0000, 3'd6, 6'd1, 6'h3f, 5, 4, 3, 2, 1, 0}, 0);
    push_drain();

    // random: merges after a clear, mixed with repeats of the first merge and more clears
    while (n_items < N_ITEMS) begin
      it = rand_merge();
      it.mode = MODE_CLEAR;
      push_item(it, rand_gap());
      base = rand_merge();
      push_item(base, rand_gap());
      repeat ($urandom_range(0, 6)) begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          push_item(base, rand_gap());
        end else if (r == 3) begin
          it = rand_merge();
          it.mode = MODE_CLEAR;
          push_item(it, rand_gap());
        end else begin
          push_item(rand_merge(), rand_gap());
        end
      end
      if ($urandom_range(0, 19) == 0) push_drain();
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (stim_q.size() != 0 || start || n_sent != n_rcvd) @(negedge clk);
    repeat (TAIL) @(negedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      errors++;
    end
    $display("Ran %0d items: %0d clears and %0d merges, %0d merges stopped on a clash.",
             n_sent, n_clears, n_merges, n_conflicts);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
sv/ltpm_pkg.sv
sv/ltpm_addr_unit.sv
sv/ltpm_table.sv
sv/ltpm_ctrl.sv
sv/lut_truth_table_permute_merge.sv
bench/lut_truth_table_permute_merge_tb.sv
